// ----- hw/rtl/gps_pkg.sv -----
// Shared types and constants for the GA parent selector.
// Used by the channel interfaces, the selection cells, the cell chain and
// the top level. No dependencies.
package gps_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_ENTRIES_DEF  = 256;
  localparam int FITNESS_BITS_DEF = 32;

  // Fixed field widths of the channels and registers
  localparam int FUNC_W   = 1;
  localparam int ID_W     = 8;
  localparam int FIT_IN_W = 32;
  localparam int THR_W    = 40;
  localparam int SEL_W    = 8;
  localparam int CNT_W    = 9;

  // Configuration port
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 4;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TCOUNT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PCOUNT = 2'd2;

  localparam logic [CNT_W-1:0] TCOUNT_RST = 9'd2;
  localparam logic [CNT_W-1:0] PCOUNT_RST = 9'd256;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_DRAW = 1'b1;

  // Selection modes
  localparam logic MODE_ROULETTE   = 1'b0;
  localparam logic MODE_TOURNAMENT = 1'b1;

  // Broadcast commands from the controller to every cell
  typedef struct packed {
    logic wr_en;     // load transfer: write the addressed cell
    logic seen_clr;  // drop the tournament record in every cell
  } cell_cmd_t;

  // Control part of the draw token that travels down the chain
  typedef struct packed {
    logic valid;  // token present in this stage
    logic tourn;  // tournament draw, else roulette draw
    logic found;  // roulette: cumulative sum has reached the threshold
    logic hit;    // tournament: candidate cell has been passed
    logic seen;   // tournament: candidate was already in the record
  } tok_ctl_t;

endpackage

// ----- hw/rtl/gps_if.sv -----
// Channel interfaces for the GA parent selector: input items and results.
// Depends on gps_pkg for the field widths.
interface gps_in_if;
  logic                          valid;
  logic                          ready;
  logic [gps_pkg::FUNC_W-1:0]    func;
  logic [gps_pkg::ID_W-1:0]      entry_index;
  logic [gps_pkg::FIT_IN_W-1:0]  fitness_value;
  logic [gps_pkg::THR_W-1:0]     threshold;
  logic [gps_pkg::ID_W-1:0]      candidate_id;

  modport source (output valid, func, entry_index, fitness_value, threshold, candidate_id,
                  input ready);
  modport sink (input valid, func, entry_index, fitness_value, threshold, candidate_id,
                output ready);
endinterface

interface gps_out_if;
  logic                       valid;
  logic                       ready;
  logic [gps_pkg::SEL_W-1:0]  selected_index;

  modport source (output valid, selected_index, input ready);
  modport sink (input valid, selected_index, output ready);
endinterface

// ----- hw/rtl/ga_parent_selector.sv -----
// GA parent selector top: registers, draw controller, result register, cell chain.
// Load transfers write the addressed cell and do not hold the input. A draw walks
// a token through all MAX_ENTRIES cells, one a cycle; input is held from the draw
// transfer until the returned token is finished, and a result waits for a free port.
// Synchronous active-low reset clears the table and the tournament record and
// sets roulette mode, 2 contestants, 256 entries.
module ga_parent_selector #(
  parameter int MAX_ENTRIES  = gps_pkg::MAX_ENTRIES_DEF,
  parameter int FITNESS_BITS = gps_pkg::FITNESS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  gps_in_if.sink                        in_chan,
  gps_out_if.source                     out_chan,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [gps_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [gps_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [gps_pkg::DATA_W-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int SUM_W = (FITNESS_BITS + IDX_W > gps_pkg::THR_W) ?
                         FITNESS_BITS + IDX_W : gps_pkg::THR_W;
  localparam int N_W   = gps_pkg::CNT_W + 1;

  // Configuration registers
  logic                      mode_r;
  logic [gps_pkg::CNT_W-1:0] tcount_r;
  logic [gps_pkg::CNT_W-1:0] pcount_r;

  // Controller state
  logic                      busy_r;
  logic                      pend_valid_r;
  logic                      out_valid_r;
  logic [gps_pkg::CNT_W-1:0] unique_r;
  logic [IDX_W-1:0]          best_r;
  logic [gps_pkg::SEL_W-1:0] out_idx_r;

  // Returned token
  gps_pkg::tok_ctl_t         pend_ctl_r;
  logic [IDX_W-1:0]          pend_sel_r;
  logic [gps_pkg::ID_W-1:0]  pend_id_r;
  logic [IDX_W-1:0]          pend_best_r;
  logic [FITNESS_BITS-1:0]   pend_fid_r;
  logic [FITNESS_BITS-1:0]   pend_fbest_r;

  // Chain connections
  gps_pkg::cell_cmd_t        cmd;
  gps_pkg::tok_ctl_t         launch_ctl;
  logic [IDX_W-1:0]          launch_best;
  gps_pkg::tok_ctl_t         end_ctl;
  logic [IDX_W-1:0]          end_sel;
  logic [gps_pkg::ID_W-1:0]  end_id;
  logic [IDX_W-1:0]          end_best;
  logic [FITNESS_BITS-1:0]   end_fid;
  logic [FITNESS_BITS-1:0]   end_fbest;

  logic                          cfg_wr;
  logic [gps_pkg::REG_IDX_W-1:0] cfg_idx;
  logic                          tour_clr;
  logic                          in_xfer;
  logic                          load_xfer;
  logic                          draw_xfer;
  logic [IDX_W-1:0]              last;
  logic [N_W-1:0]                n_use;
  logic [N_W-1:0]                t_req;
  logic [N_W-1:0]                needed;
  logic [gps_pkg::CNT_W-1:0]     uniq_inc;
  logic [IDX_W-1:0]              id_idx;
  logic [IDX_W-1:0]              win;
  logic [IDX_W-1:0]              res_idx;
  logic                          res_need;
  logic                          t_commit;
  logic                          t_emit;
  logic                          can_out;
  logic                          fire;

  // Configuration port decode
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[gps_pkg::ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign tour_clr   = cfg_wr && ((cfg_idx == gps_pkg::REG_TCOUNT) ||
                                 (cfg_idx == gps_pkg::REG_PCOUNT));

  always_comb begin
    case (cfg_idx)
      gps_pkg::REG_MODE:   cfg_prdata = gps_pkg::DATA_W'(mode_r);
      gps_pkg::REG_TCOUNT: cfg_prdata = gps_pkg::DATA_W'(tcount_r);
      gps_pkg::REG_PCOUNT: cfg_prdata = gps_pkg::DATA_W'(pcount_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // Entries in use and contestants needed, both clamped
  always_comb begin
    if (pcount_r == '0) begin
      last = '0;
    end else if (32'(pcount_r) > 32'(MAX_ENTRIES)) begin
      last = IDX_W'(MAX_ENTRIES - 1);
    end else begin
      last = IDX_W'(pcount_r - gps_pkg::CNT_W'(1));
    end
  end

  assign n_use  = N_W'(last) + N_W'(1);
  assign t_req  = (tcount_r == '0) ? N_W'(1) : N_W'(tcount_r);
  assign needed = (t_req > n_use) ? n_use : t_req;

  // Input side
  assign in_chan.ready = !busy_r;
  assign in_xfer       = in_chan.valid && !busy_r;
  assign load_xfer     = in_xfer && (in_chan.func == gps_pkg::FUNC_LOAD);
  assign draw_xfer     = in_xfer && (in_chan.func == gps_pkg::FUNC_DRAW);

  // Launch a draw token; a new tournament starts from the last entry in use
  always_comb begin
    launch_ctl       = '0;
    launch_ctl.valid = draw_xfer;
    launch_ctl.tourn = (mode_r == gps_pkg::MODE_TOURNAMENT);
  end
  assign launch_best = (unique_r == '0) ? last : best_r;

  assign cmd.wr_en    = load_xfer;
  assign cmd.seen_clr = tour_clr || (fire && t_emit);

  gps_chain #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .FITNESS_BITS (FITNESS_BITS),
    .IDX_W        (IDX_W),
    .SUM_W        (SUM_W)
  ) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (cmd),
    .wr_idx_i   (in_chan.entry_index),
    .wr_data_i  (FITNESS_BITS'(in_chan.fitness_value)),
    .last_i     (last),
    .ctl_i      (launch_ctl),
    .thr_i      (in_chan.threshold),
    .id_i       (in_chan.candidate_id),
    .best_i     (launch_best),
    .ctl_o      (end_ctl),
    .sel_o      (end_sel),
    .id_o       (end_id),
    .best_o     (end_best),
    .fit_id_o   (end_fid),
    .fit_best_o (end_fbest)
  );

  // Finish the returned token: pick the result and the tournament update
  assign id_idx   = IDX_W'(pend_id_r);
  assign uniq_inc = unique_r + gps_pkg::CNT_W'(1);
  assign win      = (pend_fid_r > pend_fbest_r) ? id_idx : pend_best_r;

  always_comb begin
    res_need = 1'b0;
    res_idx  = last;
    t_commit = 1'b0;
    t_emit   = 1'b0;
    if (!pend_ctl_r.tourn) begin
      res_need = 1'b1;
      res_idx  = pend_ctl_r.found ? pend_sel_r : last;
    end else if (pend_ctl_r.hit && !pend_ctl_r.seen) begin
      t_commit = 1'b1;
      if (N_W'(uniq_inc) >= needed) begin
        res_need = 1'b1;
        t_emit   = 1'b1;
        res_idx  = win;
      end
    end
  end

  assign can_out = !out_valid_r || out_chan.ready;
  assign fire    = pend_valid_r && (!res_need || can_out);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= gps_pkg::MODE_ROULETTE;
      tcount_r     <= gps_pkg::TCOUNT_RST;
      pcount_r     <= gps_pkg::PCOUNT_RST;
      busy_r       <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      unique_r     <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          gps_pkg::REG_MODE:   mode_r   <= cfg_pwdata[0];
          gps_pkg::REG_TCOUNT: tcount_r <= cfg_pwdata[gps_pkg::CNT_W-1:0];
          gps_pkg::REG_PCOUNT: pcount_r <= cfg_pwdata[gps_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
      if (draw_xfer) begin
        busy_r <= 1'b1;
      end else if (fire) begin
        busy_r <= 1'b0;
      end
      if (end_ctl.valid) begin
        pend_valid_r <= 1'b1;
      end else if (fire) begin
        pend_valid_r <= 1'b0;
      end
      if (fire && res_need) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (tour_clr) begin
        unique_r <= '0;
      end else if (fire && t_commit) begin
        unique_r <= t_emit ? '0 : uniq_inc;
      end
    end
  end

  // Payload registers: returned token, tournament best, result
  always_ff @(posedge clk) begin
    if (end_ctl.valid) begin
      pend_ctl_r   <= end_ctl;
      pend_sel_r   <= end_sel;
      pend_id_r    <= end_id;
      pend_best_r  <= end_best;
      pend_fid_r   <= end_fid;
      pend_fbest_r <= end_fbest;
    end
    if (fire && t_commit) begin
      best_r <= win;
    end
    if (fire && res_need) begin
      out_idx_r <= gps_pkg::SEL_W'(res_idx);
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.selected_index = out_idx_r;

endmodule

// ----- hw/rtl/gps_cell.sv -----
// One selection cell: holds one fitness entry and its tournament seen bit,
// and advances the draw token by one stage. Depends on gps_pkg.
module gps_cell #(
  parameter int INDEX        = 0,
  parameter int IDX_W        = 8,
  parameter int FITNESS_BITS = gps_pkg::FITNESS_BITS_DEF,
  parameter int SUM_W        = 40
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gps_pkg::cell_cmd_t          cmd_i,
  input  logic [gps_pkg::ID_W-1:0]    wr_idx_i,
  input  logic [FITNESS_BITS-1:0]     wr_data_i,
  input  logic [IDX_W-1:0]            last_i,
  input  gps_pkg::tok_ctl_t           ctl_i,
  input  logic [SUM_W-1:0]            sum_i,
  input  logic [gps_pkg::THR_W-1:0]   thr_i,
  input  logic [IDX_W-1:0]            sel_i,
  input  logic [gps_pkg::ID_W-1:0]    id_i,
  input  logic [IDX_W-1:0]            best_i,
  input  logic [FITNESS_BITS-1:0]     fit_id_i,
  input  logic [FITNESS_BITS-1:0]     fit_best_i,
  output gps_pkg::tok_ctl_t           ctl_o,
  output logic [SUM_W-1:0]            sum_o,
  output logic [gps_pkg::THR_W-1:0]   thr_o,
  output logic [IDX_W-1:0]            sel_o,
  output logic [gps_pkg::ID_W-1:0]    id_o,
  output logic [IDX_W-1:0]            best_o,
  output logic [FITNESS_BITS-1:0]     fit_id_o,
  output logic [FITNESS_BITS-1:0]     fit_best_o
);

  localparam logic [31:0]      IDX_WORD = 32'(INDEX);
  localparam logic [IDX_W-1:0] IDX_C    = IDX_W'(INDEX);

  logic [FITNESS_BITS-1:0] fit_r;
  logic                    seen_r;

  gps_pkg::tok_ctl_t       ctl_r, ctl_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [gps_pkg::THR_W-1:0] thr_r;
  logic [IDX_W-1:0]        sel_r, sel_nxt;
  logic [gps_pkg::ID_W-1:0] id_r;
  logic [IDX_W-1:0]        best_r;
  logic [FITNESS_BITS-1:0] fit_id_r, fit_id_nxt;
  logic [FITNESS_BITS-1:0] fit_best_r, fit_best_nxt;

  logic             active;
  logic             id_hit;
  logic             best_hit;
  logic             wr_hit;
  logic             mark;
  logic [SUM_W-1:0] sum_add;

  assign active   = IDX_C <= last_i;
  assign id_hit   = 32'(id_i) == IDX_WORD;
  assign best_hit = best_i == IDX_C;
  assign wr_hit   = cmd_i.wr_en && (32'(wr_idx_i) == IDX_WORD);
  assign sum_add  = sum_i + SUM_W'(fit_r);

  // Work on the token if this entry is in use, else pass it on unchanged
  always_comb begin
    ctl_nxt      = ctl_i;
    sum_nxt      = sum_i;
    sel_nxt      = sel_i;
    fit_id_nxt   = fit_id_i;
    fit_best_nxt = fit_best_i;
    mark         = 1'b0;
    if (ctl_i.valid && active) begin
      if (!ctl_i.tourn) begin
        if (!ctl_i.found) begin
          sum_nxt = sum_add;
          if (sum_add >= SUM_W'(thr_i)) begin
            ctl_nxt.found = 1'b1;
            sel_nxt       = IDX_C;
          end
        end
      end else begin
        if (id_hit) begin
          ctl_nxt.hit  = 1'b1;
          ctl_nxt.seen = seen_r;
          fit_id_nxt   = fit_r;
          mark         = !seen_r;
        end
        if (best_hit) begin
          fit_best_nxt = fit_r;
        end
      end
    end
  end

  // Hold the entry and the seen bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_r  <= '0;
      seen_r <= 1'b0;
    end else begin
      if (wr_hit) begin
        fit_r <= wr_data_i;
      end
      if (cmd_i.seen_clr) begin
        seen_r <= 1'b0;
      end else if (mark) begin
        seen_r <= 1'b1;
      end
    end
  end

  // Advance the token control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  // Advance the token payload
  always_ff @(posedge clk) begin
    sum_r      <= sum_nxt;
    thr_r      <= thr_i;
    sel_r      <= sel_nxt;
    id_r       <= id_i;
    best_r     <= best_i;
    fit_id_r   <= fit_id_nxt;
    fit_best_r <= fit_best_nxt;
  end

  assign ctl_o      = ctl_r;
  assign sum_o      = sum_r;
  assign thr_o      = thr_r;
  assign sel_o      = sel_r;
  assign id_o       = id_r;
  assign best_o     = best_r;
  assign fit_id_o   = fit_id_r;
  assign fit_best_o = fit_best_r;

endmodule

// ----- hw/rtl/gps_chain.sv -----
// Row of selection cells, one per table entry, linked stage to stage.
// Depends on gps_pkg and gps_cell.
module gps_chain #(
  parameter int MAX_ENTRIES  = gps_pkg::MAX_ENTRIES_DEF,
  parameter int FITNESS_BITS = gps_pkg::FITNESS_BITS_DEF,
  parameter int IDX_W        = $clog2(MAX_ENTRIES),
  parameter int SUM_W        = 40
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gps_pkg::cell_cmd_t          cmd_i,
  input  logic [gps_pkg::ID_W-1:0]    wr_idx_i,
  input  logic [FITNESS_BITS-1:0]     wr_data_i,
  input  logic [IDX_W-1:0]            last_i,
  input  gps_pkg::tok_ctl_t           ctl_i,
  input  logic [gps_pkg::THR_W-1:0]   thr_i,
  input  logic [gps_pkg::ID_W-1:0]    id_i,
  input  logic [IDX_W-1:0]            best_i,
  output gps_pkg::tok_ctl_t           ctl_o,
  output logic [IDX_W-1:0]            sel_o,
  output logic [gps_pkg::ID_W-1:0]    id_o,
  output logic [IDX_W-1:0]            best_o,
  output logic [FITNESS_BITS-1:0]     fit_id_o,
  output logic [FITNESS_BITS-1:0]     fit_best_o
);

  gps_pkg::tok_ctl_t         ctl   [MAX_ENTRIES+1];
  logic [SUM_W-1:0]          sum   [MAX_ENTRIES+1];
  logic [gps_pkg::THR_W-1:0] thr   [MAX_ENTRIES+1];
  logic [IDX_W-1:0]          sel   [MAX_ENTRIES+1];
  logic [gps_pkg::ID_W-1:0]  id    [MAX_ENTRIES+1];
  logic [IDX_W-1:0]          best  [MAX_ENTRIES+1];
  logic [FITNESS_BITS-1:0]   fid   [MAX_ENTRIES+1];
  logic [FITNESS_BITS-1:0]   fbest [MAX_ENTRIES+1];

  // Fresh token enters the first cell
  assign ctl[0]   = ctl_i;
  assign sum[0]   = '0;
  assign thr[0]   = thr_i;
  assign sel[0]   = '0;
  assign id[0]    = id_i;
  assign best[0]  = best_i;
  assign fid[0]   = '0;
  assign fbest[0] = '0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    gps_cell #(
      .INDEX        (g),
      .IDX_W        (IDX_W),
      .FITNESS_BITS (FITNESS_BITS),
      .SUM_W        (SUM_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd_i      (cmd_i),
      .wr_idx_i   (wr_idx_i),
      .wr_data_i  (wr_data_i),
      .last_i     (last_i),
      .ctl_i      (ctl[g]),
      .sum_i      (sum[g]),
      .thr_i      (thr[g]),
      .sel_i      (sel[g]),
      .id_i       (id[g]),
      .best_i     (best[g]),
      .fit_id_i   (fid[g]),
      .fit_best_i (fbest[g]),
      .ctl_o      (ctl[g+1]),
      .sum_o      (sum[g+1]),
      .thr_o      (thr[g+1]),
      .sel_o      (sel[g+1]),
      .id_o       (id[g+1]),
      .best_o     (best[g+1]),
      .fit_id_o   (fid[g+1]),
      .fit_best_o (fbest[g+1])
    );
  end

  // Token leaving the last cell goes back to the controller; the running sum
  // and threshold are spent by then
  assign ctl_o      = ctl[MAX_ENTRIES];
  assign sel_o      = sel[MAX_ENTRIES];
  assign id_o       = id[MAX_ENTRIES];
  assign best_o     = best[MAX_ENTRIES];
  assign fit_id_o   = fid[MAX_ENTRIES];
  assign fit_best_o = fbest[MAX_ENTRIES];

  logic unused_tail;
  assign unused_tail = ^{sum[MAX_ENTRIES], thr[MAX_ENTRIES]};

endmodule

// ----- test/tb_top.sv -----
// Testbench for ga_parent_selector: directed and random load, roulette and
// tournament transfers checked against a selection predictor held in the bench.
// Depends on gps_pkg, gps_if.sv and the ga_parent_selector RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int TBL_DEPTH     = gps_pkg::MAX_ENTRIES_DEF;
  localparam int FIT_W         = gps_pkg::FITNESS_BITS_DEF;
  localparam int FUNC_W        = gps_pkg::FUNC_W;
  localparam int ID_W          = gps_pkg::ID_W;
  localparam int FIT_IN_W      = gps_pkg::FIT_IN_W;
  localparam int THR_W         = gps_pkg::THR_W;
  localparam int SEL_W         = gps_pkg::SEL_W;
  localparam int CNT_W         = gps_pkg::CNT_W;
  localparam int ADDR_W        = gps_pkg::ADDR_W;
  localparam int DATA_W        = gps_pkg::DATA_W;
  localparam int REG_IDX_W     = gps_pkg::REG_IDX_W;
  localparam int SETTLE_CYCLES = TBL_DEPTH + 10;
  localparam int STALL_LIMIT   = 8000;
  localparam int HOLD_CYCLES   = 1500;

  typedef struct {
    logic [FUNC_W-1:0]   func;
    logic [ID_W-1:0]     entry_index;
    logic [FIT_IN_W-1:0] fitness_value;
    logic [THR_W-1:0]    threshold;
    logic [ID_W-1:0]     candidate_id;
  } sel_item_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  gps_in_if  in_if ();
  gps_out_if out_if ();

  ga_parent_selector u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Predictor state: fitness table, tournament record and register copies
  logic [FIT_W-1:0] fit_tbl [TBL_DEPTH];
  bit               contest_seen [TBL_DEPTH];
  int unsigned      contest_cnt;
  int unsigned      best_idx;
  logic             mode_r;
  logic [CNT_W-1:0] tcount_r;
  logic [CNT_W-1:0] pcount_r;

  logic [SEL_W-1:0] expected_sel [$];
  int               sel_errors;
  int unsigned      items_sent;
  int unsigned      snd_idle_pct;
  int unsigned      rcv_idle_pct;
  int               rx_hold_left;
  int               stall_cnt;

  // Clock: 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned pop_used();
    int unsigned n;
    n = pcount_r;
    if (n == 0) n = 1;
    if (n > TBL_DEPTH) n = TBL_DEPTH;
    return n;
  endfunction

  function automatic int unsigned contest_needed();
    int unsigned n;
    n = tcount_r;
    if (n == 0) n = 1;
    if (n > pop_used()) n = pop_used();
    return n;
  endfunction

  function automatic void clear_contest();
    foreach (contest_seen[i]) contest_seen[i] = 1'b0;
    contest_cnt = 0;
    best_idx    = pop_used() - 1;
  endfunction

  function automatic logic [63:0] wheel_sum();
    logic [63:0] acc;
    acc = '0;
    for (int i = 0; i < pop_used(); i++) acc += fit_tbl[i];
    return acc;
  endfunction

  // Advance the predictor by one accepted input transfer
  function automatic void select_parent(input sel_item_t item);
    int unsigned n;
    int unsigned pick;
    int unsigned id;
    logic [63:0] acc;
    n = pop_used();
    if (item.func == gps_pkg::FUNC_LOAD) begin
      fit_tbl[item.entry_index] = item.fitness_value[FIT_W-1:0];
    end else if (mode_r == gps_pkg::MODE_ROULETTE) begin
      // walk the cumulative wheel, saturate to the last entry in use
      acc  = '0;
      pick = n - 1;
      for (int i = 0; i < n; i++) begin
        acc += fit_tbl[i];
        if (acc >= 64'(item.threshold)) begin
          pick = i;
          break;
        end
      end
      expected_sel = {expected_sel, SEL_W'(pick)};
    end else begin
      id = item.candidate_id;
      if (id < n && !contest_seen[id]) begin
        if (contest_cnt == 0) best_idx = n - 1;
        contest_seen[id] = 1'b1;
        contest_cnt++;
        if (fit_tbl[id] > fit_tbl[best_idx % TBL_DEPTH]) best_idx = id;
        if (contest_cnt >= contest_needed()) begin
          expected_sel = {expected_sel, SEL_W'(best_idx)};
          clear_contest();
        end
      end
    end
  endfunction

  function automatic void apply_config(input logic [REG_IDX_W-1:0] idx,
                                       input logic [DATA_W-1:0] data);
    case (idx)
      gps_pkg::REG_MODE: begin
        mode_r = data[0];
      end
      gps_pkg::REG_TCOUNT: begin
        tcount_r = data[CNT_W-1:0];
        clear_contest();
      end
      gps_pkg::REG_PCOUNT: begin
        pcount_r = data[CNT_W-1:0];
        clear_contest();
      end
      default: begin
      end
    endcase
  endfunction

  // Stimulus shaping
  function automatic sel_item_t random_fields();
    sel_item_t item;
    item.func          = FUNC_W'($urandom);
    item.entry_index   = ID_W'($urandom);
    item.fitness_value = $urandom;
    item.threshold     = THR_W'({$urandom, $urandom});
    item.candidate_id  = ID_W'($urandom);
    return item;
  endfunction

  function automatic logic [FIT_IN_W-1:0] pick_fitness();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 22) return '1;
    if (r < 50) return FIT_IN_W'($urandom_range(1000));
    return $urandom;
  endfunction

  function automatic logic [THR_W-1:0] pick_threshold();
    int unsigned r;
    logic [63:0] total;
    total = wheel_sum();
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return THR_W'(total);
    if (r < 15) return THR_W'(total + 1);
    if (r < 20) return THR_W'({$urandom, $urandom});
    if (r < 24) return '1;
    if (total == 0) return THR_W'($urandom_range(3));
    return THR_W'({$urandom, $urandom} % (total + 1));
  endfunction

  function automatic logic [ID_W-1:0] pick_candidate();
    int unsigned n;
    int unsigned r;
    int unsigned start;
    n = pop_used();
    r = $urandom_range(99);
    // out-of-range contestant
    if (r < 8 && n < TBL_DEPTH) return ID_W'($urandom_range(TBL_DEPTH - 1, n));
    // repeat of a contestant already in the record
    if (r < 20 && contest_cnt > 0) begin
      start = $urandom_range(n - 1);
      for (int i = 0; i < n; i++)
        if (contest_seen[(start + i) % n]) return ID_W'((start + i) % n);
    end
    start = $urandom_range(n - 1);
    for (int i = 0; i < n; i++)
      if (!contest_seen[(start + i) % n]) return ID_W'((start + i) % n);
    return ID_W'(start);
  endfunction

  function automatic sel_item_t make_load();
    sel_item_t item;
    item      = random_fields();
    item.func = gps_pkg::FUNC_LOAD;
    if ($urandom_range(99) < 85) item.entry_index = ID_W'($urandom_range(pop_used() - 1));
    item.fitness_value = pick_fitness();
    return item;
  endfunction

  function automatic sel_item_t make_draw();
    sel_item_t item;
    item      = random_fields();
    item.func = gps_pkg::FUNC_DRAW;
    if (mode_r == gps_pkg::MODE_ROULETTE) item.threshold = pick_threshold();
    else item.candidate_id = pick_candidate();
    return item;
  endfunction

  // Offer one item, wait for its transfer, then update the predictor
  task automatic send_item(input sel_item_t item);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.func          <= item.func;
    in_if.entry_index   <= item.entry_index;
    in_if.fitness_value <= item.fitness_value;
    in_if.threshold     <= item.threshold;
    in_if.candidate_id  <= item.candidate_id;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    select_parent(item);
    items_sent++;
  endtask

  task automatic send_load(input logic [ID_W-1:0] idx, input logic [FIT_IN_W-1:0] fit);
    sel_item_t item;
    item               = random_fields();
    item.func          = gps_pkg::FUNC_LOAD;
    item.entry_index   = idx;
    item.fitness_value = fit;
    send_item(item);
  endtask

  task automatic send_draw(input logic [THR_W-1:0] thr, input logic [ID_W-1:0] id);
    sel_item_t item;
    item              = random_fields();
    item.func         = gps_pkg::FUNC_DRAW;
    item.threshold    = thr;
    item.candidate_id = id;
    send_item(item);
  endtask

  // Drop valid and let every pending result and any draw still in the chain drain
  task automatic settle_block();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_sel.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB write: setup cycle, then access cycle until pready
  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    apply_config(idx, data);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic mode, input logic [CNT_W-1:0] tc,
                            input logic [CNT_W-1:0] pc);
    settle_block();
    cfg_write(gps_pkg::REG_PCOUNT, DATA_W'(pc));
    cfg_write(gps_pkg::REG_TCOUNT, DATA_W'(tc));
    cfg_write(gps_pkg::REG_MODE, DATA_W'(mode));
  endtask

  // Roulette extremes on the reset configuration: zero, exact and overflowing thresholds
  task automatic test_roulette_edges();
    send_load(8'd0, 32'hFFFF_FFFF);
    send_load(8'd1, 32'd0);
    send_load(8'd2, 32'd5);
    send_load(8'd128, 32'h8000_0000);
    send_load(8'd255, 32'hFFFF_FFFF);
    send_draw(40'd0, 8'hFF);
    send_draw(40'h00_FFFF_FFFF, 8'h00);
    send_draw(40'h01_0000_0000, 8'hAA);
    send_draw(40'h01_0000_0005, 8'h55);
    send_draw(40'hFF_FFFF_FFFF, 8'h00);
  endtask

  // Population count of zero and above the table size
  task automatic test_population_limits();
    settle_block();
    cfg_write(gps_pkg::REG_PCOUNT, DATA_W'(0));
    send_draw(40'hFF_FFFF_FFFF, 8'h00);
    settle_block();
    cfg_write(gps_pkg::REG_PCOUNT, DATA_W'(300));
    send_draw(40'hFF_FFFF_FFFF, 8'hFF);
  endtask

  // Ignored ids, ties, mode switch mid-tournament, record clear on count writes
  task automatic test_tournament_rules();
    set_config(gps_pkg::MODE_TOURNAMENT, CNT_W'(3), CNT_W'(8));
    send_load(8'd0, 32'd0);
    send_load(8'd2, 32'd100);
    send_load(8'd5, 32'd200);
    send_load(8'd7, 32'd100);
    send_draw(40'd0, 8'd9);
    send_draw(40'd0, 8'd2);
    send_draw(40'd0, 8'd2);
    // a roulette draw must leave the partial tournament alone
    settle_block();
    cfg_write(gps_pkg::REG_MODE, DATA_W'(gps_pkg::MODE_ROULETTE));
    send_draw(40'd0, 8'd3);
    settle_block();
    cfg_write(gps_pkg::REG_MODE, DATA_W'(gps_pkg::MODE_TOURNAMENT));
    send_draw(40'd0, 8'd5);
    send_draw(40'd0, 8'd0);
    // equal fitness does not displace the starting best
    send_draw(40'd0, 8'd2);
    send_draw(40'd0, 8'd0);
    send_draw(40'd0, 8'd1);
    // leave a partial record, then a count write must clear it
    send_draw(40'd0, 8'd5);
    settle_block();
    cfg_write(gps_pkg::REG_TCOUNT, DATA_W'(0));
    send_draw(40'd0, 8'd5);
    settle_block();
    cfg_write(gps_pkg::REG_PCOUNT, DATA_W'(4));
    cfg_write(gps_pkg::REG_TCOUNT, DATA_W'(300));
    for (int i = 0; i < 4; i++) send_draw(40'd0, ID_W'(i));
  endtask

  // Hold the result channel off for a long stretch while draws keep coming
  task automatic test_output_stall();
    set_config(gps_pkg::MODE_ROULETTE, CNT_W'(2), CNT_W'(16));
    repeat (6) send_item(make_load());
    rx_hold_left = HOLD_CYCLES;
    repeat (12) send_item(make_draw());
  endtask

  task automatic run_segment(input int unsigned n_items);
    logic             mode;
    logic [CNT_W-1:0] pc;
    logic [CNT_W-1:0] tc;
    int unsigned      n;
    int unsigned      r;
    int unsigned      k;
    r  = $urandom_range(99);
    pc = (r < 8)  ? CNT_W'(0) :
         (r < 16) ? CNT_W'(1) :
         (r < 26) ? CNT_W'(256) :
         (r < 32) ? CNT_W'($urandom_range(511, 257)) :
         (r < 80) ? CNT_W'($urandom_range(16, 2)) : CNT_W'($urandom_range(255, 17));
    n  = (pc == 0) ? 1 : (pc > TBL_DEPTH) ? TBL_DEPTH : pc;
    r  = $urandom_range(99);
    tc = (r < 10) ? CNT_W'(0) :
         (r < 20) ? CNT_W'(1) :
         (r < 30 && n <= 16) ? CNT_W'($urandom_range(511, n)) :
         CNT_W'($urandom_range((n < 6) ? n : 6, 1));
    mode = logic'($urandom_range(1));
    set_config(mode, tc, pc);
    k = $urandom_range(24, 4);
    repeat (k) send_item(make_load());
    repeat (n_items - k) begin
      if ($urandom_range(99) < 18) send_item(make_load());
      else send_item(make_draw());
    end
  endtask

  task automatic run_random_phase(input int unsigned n_items);
    int unsigned target;
    target = items_sent + n_items;
    while (items_sent < target) run_segment($urandom_range(110, 50));
  endtask

  // Receiver: random ready, or a long hold counted down here
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_if.ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Check each result transfer against the oldest expected selection
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_sel.size() == 0) begin
        sel_errors++;
        if (sel_errors <= 10)
          $display("[%0t] unexpected selection %0d", $realtime, out_if.selected_index);
      end else if (out_if.selected_index !== expected_sel[0]) begin
        sel_errors++;
        if (sel_errors <= 10)
          $display("[%0t] selected_index mismatch: expected %0d, got %0d",
                   $realtime, expected_sel[0], out_if.selected_index);
        void'(expected_sel.pop_front());
      end else begin
        void'(expected_sel.pop_front());
      end
    end
  end

  // Watchdog: cycles without any transfer on any port
  always @(posedge clk) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready === 1'b1)) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n               = 1'b0;
    cfg_psel            = 1'b0;
    cfg_penable         = 1'b0;
    cfg_pwrite          = 1'b0;
    cfg_paddr           = '0;
    cfg_pwdata          = '0;
    in_if.valid         = 1'b0;
    in_if.func          = gps_pkg::FUNC_LOAD;
    in_if.entry_index   = '0;
    in_if.fitness_value = '0;
    in_if.threshold     = '0;
    in_if.candidate_id  = '0;
    sel_errors          = 0;
    items_sent          = 0;
    rx_hold_left        = 0;
    stall_cnt           = 0;
    snd_idle_pct        = 14;
    rcv_idle_pct        = 49;
    foreach (fit_tbl[i]) fit_tbl[i] = '0;
    mode_r   = gps_pkg::MODE_ROULETTE;
    tcount_r = gps_pkg::TCOUNT_RST;
    pcount_r = gps_pkg::PCOUNT_RST;
    clear_contest();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_roulette_edges();
    test_population_limits();
    test_tournament_rules();
    test_output_stall();
    run_random_phase(440);

    snd_idle_pct = 49;
    rcv_idle_pct = 14;
    run_random_phase(480);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_random_phase(480);

    settle_block();
    sel_errors += expected_sel.size();
    if (sel_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/gps_pkg.sv
hw/rtl/gps_if.sv
hw/rtl/gps_cell.sv
hw/rtl/gps_chain.sv
hw/rtl/ga_parent_selector.sv
test/tb_top.sv
